FILE: sv/fohpwm_pkg.sv
// fohpwm_pkg: shared types, widths and codes for the FOH PWM compare update block.
// No dependencies; imported by fohpwm_div and foh_pwm_compare_update.
package fohpwm_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);

    localparam int SAMPLE_W  = 12;
    localparam int COUNTER_W = 16;
    localparam int SCALE_W   = 14;
    localparam int THRESH_W  = 16;

    // counter - sample, signed; its magnitude; slope terms
    localparam int DIFF_W     = COUNTER_W + 2;
    localparam int DIFF_MAG_W = COUNTER_W + 1;
    localparam int SLOPE_W    = 16;

    // divider operand widths: |num| < 2^31, |slope| < 2^15
    localparam int NUM_W = DIFF_MAG_W + SCALE_W;
    localparam int DEN_W = SLOPE_W - 1;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [SCALE_W-1:0]  HOLD_SCALE_RST = SCALE_W'(3000);
    localparam logic [THRESH_W-1:0] REJECT_RST     = '0;

    // register index codes (byte address bit 2)
    typedef enum logic
    {
        REG_HOLD_SCALE = 1'b0,
        REG_REJECT     = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed
    {
        logic [SAMPLE_W-1:0]  sample;
        logic [COUNTER_W-1:0] counter_a;
        logic                 up_a;
        logic [COUNTER_W-1:0] counter_b;
        logic                 up_b;
        logic [COUNTER_W-1:0] counter_c;
        logic                 up_c;
    } item_t;

    typedef struct packed
    {
        logic [COUNTER_W-1:0] compare_a;
        logic                 write_a;
        logic [COUNTER_W-1:0] compare_b;
        logic                 write_b;
        logic [COUNTER_W-1:0] compare_c;
        logic                 write_c;
    } result_t;

endpackage

FILE: sv/fohpwm_div.sv
// fohpwm_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on fohpwm_pkg for default operand widths.
module fohpwm_div
    import fohpwm_pkg::*;
#(
    parameter int NUM_BITS = NUM_W,
    parameter int DEN_BITS = DEN_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] den_reg, den_next;

    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS+1:0] trial;
    logic                fits;

    // trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_BITS-1]};
        trial   = {1'b0, shifted} - {2'b00, den_reg};
        fits    = ~trial[DEN_BITS+1];
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_BITS);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
            quo_next = {quo_reg[NUM_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: sv/foh_pwm_compare_update.sv
// foh_pwm_compare_update: top level of the first-order-hold PWM compare update block.
// Depends on fohpwm_pkg and fohpwm_div.
//
// Each transfer on the item channel brings a 12-bit sample plus counter value and
// count direction for three PWM carriers; each transfer on the result channel
// returns one new compare value and write flag per carrier. The slope term is
// sample - previous sample - hold_scale (counting up) or that plus 2*hold_scale
// (counting down); the offset is (counter - sample) * hold_scale / slope,
// truncated toward zero, and the compare value is counter +/- offset, cut to
// 16 bits. A channel is flagged for writing only if the offset is above
// reject_threshold and the slope is non-zero; otherwise its compare value is 0.
// Channels are worked one after another through a single multiplier and a
// shared restoring divider: per channel a multiply step, the division and a
// finishing step, and an item occupies the block from acceptance until the
// next item can be taken (shorter when a slope is zero and the division is
// skipped). The divider yields one quotient bit per clock. item_stall stays high
// while an item is being worked. The result
// sits in an output register, so a new item is accepted while the previous
// result still waits; the block only holds back at the end of an item if that
// register has not yet been emptied. The previous sample resets to 0.
// Registers (APB, byte addresses): 0x0 hold_scale (14 bits, reset 3000),
// 0x4 reject_threshold (16 bits, reset 0). Write them only when idle.
module foh_pwm_compare_update
    import fohpwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,

    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SCALE_W-1:0]  hold_scale_reg;
    logic [THRESH_W-1:0] reject_reg;
    reg_idx_t            reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_comb
    begin
        unique case (reg_idx)
            REG_HOLD_SCALE: prdata = DATA_W'(hold_scale_reg);
            REG_REJECT:     prdata = DATA_W'(reject_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer state and captured item
    // ---------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [CH_IDX_W-1:0]   ch_reg, ch_next;
    logic                  result_valid_reg, result_valid_next;
    logic [SAMPLE_W-1:0]   last_sample_reg;

    logic [SAMPLE_W-1:0]   sample_reg;
    logic [COUNTER_W-1:0]  counter_reg [NUM_CHANNELS];
    logic                  up_reg      [NUM_CHANNELS];
    logic [SLOPE_W-1:0]    slope_up_reg, slope_dn_reg;
    logic                  zero_reg;
    logic                  quot_neg_reg;
    logic [COUNTER_W-1:0]  cmp_reg     [NUM_CHANNELS];
    logic                  wr_reg      [NUM_CHANNELS];
    result_t               result_reg;

    logic [COUNTER_W-1:0]  item_counter [NUM_CHANNELS];
    logic                  item_up      [NUM_CHANNELS];

    // control strobes
    logic accept, div_start, fin_en, out_load, out_free, last_ch;

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    logic [SLOPE_W-1:0]    sample_delta;
    logic [SLOPE_W-1:0]    slope_up_new, slope_dn_new;
    logic [COUNTER_W-1:0]  cur_counter;
    logic                  cur_up;
    logic [DIFF_W-1:0]     diff;
    logic [DIFF_W-1:0]     diff_abs;
    logic [DIFF_MAG_W-1:0] diff_mag;
    logic [NUM_W-1:0]      product;
    logic [SLOPE_W-1:0]    slope_sel;
    logic [SLOPE_W-1:0]    slope_abs;
    logic                  slope_zero;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quo;
    logic                  fin_write;
    logic [COUNTER_W-1:0]  fin_cmp;

    always_comb
    begin
        item_counter[0] = item.counter_a;
        item_up[0]      = item.up_a;
        item_counter[1] = item.counter_b;
        item_up[1]      = item.up_b;
        item_counter[2] = item.counter_c;
        item_up[2]      = item.up_c;
    end

    // slopes fit 16 signed bits for every register setting
    always_comb
    begin
        sample_delta = SLOPE_W'(item.sample) - SLOPE_W'(last_sample_reg);
        slope_up_new = sample_delta - SLOPE_W'(hold_scale_reg);
        slope_dn_new = sample_delta + SLOPE_W'(hold_scale_reg);
    end

    // multiply step: |counter - sample| * hold_scale, sign kept aside
    always_comb
    begin
        cur_counter = counter_reg[ch_reg];
        cur_up      = up_reg[ch_reg];
        diff        = DIFF_W'(cur_counter) - DIFF_W'(sample_reg);
        diff_abs    = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
        diff_mag    = diff_abs[DIFF_MAG_W-1:0];
        product     = NUM_W'(diff_mag) * NUM_W'(hold_scale_reg);
        slope_sel   = cur_up ? slope_up_reg : slope_dn_reg;
        slope_abs   = slope_sel[SLOPE_W-1] ? (SLOPE_W'(0) - slope_sel) : slope_sel;
        slope_zero  = (slope_sel == '0);
    end

    fohpwm_div
    #(
        .NUM_BITS (NUM_W),
        .DEN_BITS (DEN_W)
    )
    u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (product),
        .den   (slope_abs[DEN_W-1:0]),
        .done  (div_done),
        .quo   (div_quo)
    );

    // finish step: a negative quotient never beats the (non-negative) threshold
    always_comb
    begin
        fin_write = ~zero_reg & ~quot_neg_reg & (div_quo > NUM_W'(reject_reg));
        if (!fin_write)
            fin_cmp = '0;
        else if (cur_up)
            fin_cmp = cur_counter + div_quo[COUNTER_W-1:0];
        else
            fin_cmp = cur_counter - div_quo[COUNTER_W-1:0];
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign out_free = ~result_valid_reg | ~result_stall;
    assign last_ch  = (ch_reg == CH_IDX_W'(NUM_CHANNELS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (item_valid)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = slope_zero ? ST_FIN : ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_FIN;
            ST_FIN:
                state_next = last_ch ? ST_OUT : ST_MUL;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        accept    = (state_reg == ST_IDLE) & item_valid;
        div_start = (state_reg == ST_MUL) & ~slope_zero;
        fin_en    = (state_reg == ST_FIN);
        out_load  = (state_reg == ST_OUT) & out_free;

        ch_next = ch_reg;
        if (accept)
            ch_next = '0;
        else if (fin_en && !last_ch)
            ch_next = ch_reg + CH_IDX_W'(1);

        if (out_load)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ch_reg           <= '0;
            result_valid_reg <= 1'b0;
            last_sample_reg  <= '0;
            hold_scale_reg   <= HOLD_SCALE_RST;
            reject_reg       <= REJECT_RST;
        end
        else
        begin
            state_reg        <= state_next;
            ch_reg           <= ch_next;
            result_valid_reg <= result_valid_next;
            // previous sample moves on once the whole item is done
            if (out_load)
                last_sample_reg <= sample_reg;
            if (cfg_wr && reg_idx == REG_HOLD_SCALE)
                hold_scale_reg <= pwdata[SCALE_W-1:0];
            if (cfg_wr && reg_idx == REG_REJECT)
                reject_reg <= pwdata[THRESH_W-1:0];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg   <= item.sample;
            slope_up_reg <= slope_up_new;
            slope_dn_reg <= slope_dn_new;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                counter_reg[i] <= item_counter[i];
                up_reg[i]      <= item_up[i];
            end
        end
        if (state_reg == ST_MUL)
        begin
            zero_reg     <= slope_zero;
            quot_neg_reg <= diff[DIFF_W-1] ^ slope_sel[SLOPE_W-1];
        end
        if (fin_en)
        begin
            cmp_reg[ch_reg] <= fin_cmp;
            wr_reg[ch_reg]  <= fin_write;
        end
        if (out_load)
        begin
            result_reg.compare_a <= cmp_reg[0];
            result_reg.write_a   <= wr_reg[0];
            result_reg.compare_b <= cmp_reg[1];
            result_reg.write_b   <= wr_reg[1];
            result_reg.compare_c <= cmp_reg[2];
            result_reg.write_c   <= wr_reg[2];
        end
    end

endmodule
